>>> rtl/edge_clamped_moving_average_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the moving average filter
// Shared property forms; they use the enclosing module's clk and arst_n.
// ----------------------------------------------------------------------------
`ifndef EDGE_CLAMPED_MOVING_AVERAGE_ASSERT_SVH
`define EDGE_CLAMPED_MOVING_AVERAGE_ASSERT_SVH

// The expression holds at every clock edge outside reset.
`define ECMA_ASSERT_ALWAYS(label, expr) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (expr)) \
		else $error("ecma invariant violated");

// The consequent holds in the same cycle as the antecedent.
`define ECMA_ASSERT_IMPLIES(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("ecma implication violated");

// The consequent holds in the cycle after the antecedent.
`define ECMA_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("ecma next-cycle check violated");

`endif

>>> rtl/ecma_pkg.sv
// ----------------------------------------------------------------------------
// ecma_pkg
// Constants used by the moving average filter.
// ----------------------------------------------------------------------------
package ecma_pkg;

	localparam int ECMA_MAX_RADIUS = 31;
	localparam int SAMPLE_W        = 16;
	localparam int RADIUS_W        = 5;

	localparam logic signed [SAMPLE_W-1:0] AVG_POS_LIMIT = 16'sh7FFF;
	localparam logic signed [SAMPLE_W-1:0] AVG_NEG_LIMIT = 16'sh8000;

endpackage

>>> rtl/ecma_ram.sv
// ----------------------------------------------------------------------------
// ecma_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module ecma_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

>>> rtl/ecma_div.sv
// ----------------------------------------------------------------------------
// ecma_div
// Restoring unsigned divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module ecma_div #(
	parameter int DW = 22,
	parameter int VW = 6
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	input  logic [DW-1:0] dividend,
	input  logic [VW-1:0] divisor,
	output logic          done,
	output logic [DW-1:0] quotient
);

	localparam int CW = $clog2(DW + 1);

	logic          busy_q;
	logic          done_q;
	logic [CW-1:0] cnt_q;
	logic [VW-1:0] rem_q;
	logic [DW-1:0] quo_q;
	logic [VW-1:0] dsr_q;

	logic [VW:0] shifted;
	logic [VW:0] diff;
	logic        fits;

	// The remainder stays below the divisor, so VW bits hold it.
	assign shifted = {rem_q, quo_q[DW-1]};
	assign diff    = shifted - {1'b0, dsr_q};
	assign fits    = !diff[VW];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
			rem_q  <= '0;
			quo_q  <= '0;
			dsr_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CW'(DW);
				rem_q  <= '0;
				quo_q  <= dividend;
				dsr_q  <= divisor;
			end else if (busy_q) begin
				rem_q <= fits ? diff[VW-1:0] : shifted[VW-1:0];
				quo_q <= {quo_q[DW-2:0], fits};
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CW'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	assign done     = done_q;
	assign quotient = quo_q;

endmodule

>>> rtl/edge_clamped_moving_average.sv
// ----------------------------------------------------------------------------
// edge_clamped_moving_average
// Centered boxcar average with edge replication over a 16-bit sample stream.
//
//   Channel   Handshake                    Payload
//   cfg       cfg_valid / cfg_ready        cfg_data (radius)
//   in        in_valid / in_stall          sample, last
//   out       out_valid / out_stall        average, final_res
//
// A request is accepted in ST_IDLE; each push writes and reads the RAM in ST_PUSH and
// updates the sum in ST_UPD. Each result then passes ST_DIVGO, the divide in ST_DIV
// and ST_OUT. The last request of a stream pushes radius+1 times.
// No clearing after reset: the first sample of a stream is held in a register and
// stands in for ring entries not yet written in that stream.
// A result left in the output register does not stall the next request; a second
// result waits in ST_OUT while the first is held.
// ----------------------------------------------------------------------------
module edge_clamped_moving_average
	import ecma_pkg::*;
#(
	parameter int MAX_RADIUS = ECMA_MAX_RADIUS
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       cfg_valid,
	output logic                       cfg_ready,
	input  logic [RADIUS_W-1:0]        cfg_data,
	input  logic                       in_valid,
	output logic                       in_stall,
	input  logic signed [SAMPLE_W-1:0] sample,
	input  logic                       last,
	output logic                       out_valid,
	input  logic                       out_stall,
	output logic signed [SAMPLE_W-1:0] average,
	output logic                       final_res
);

	`include "edge_clamped_moving_average_assert.svh"

	localparam int RW    = $clog2(MAX_RADIUS + 1);
	localparam int AW    = RW + 1;
	localparam int DEPTH = 1 << AW;
	localparam int SUMW  = SAMPLE_W + AW;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_PUSH,
		ST_UPD,
		ST_DIVGO,
		ST_DIV,
		ST_OUT
	} state_t;

	state_t                     state_q;
	logic [RADIUS_W-1:0]        radius_q;
	logic [RW-1:0]              seen_q;
	logic [RW-1:0]              pend_q;
	logic [RW-1:0]              k_q;
	logic [AW-1:0]              head_q;
	logic [AW-1:0]              cnt_q;
	logic signed [SUMW-1:0]     sum_q;
	logic signed [SAMPLE_W-1:0] s_q;
	logic signed [SAMPLE_W-1:0] first_q;
	logic                       last_q;
	logic                       flush_q;
	logic                       fin_q;
	logic                       out_valid_q;
	logic signed [SAMPLE_W-1:0] average_q;
	logic                       final_q;

	logic [RW-1:0]              r_eff;
	logic [AW-1:0]              len_w;
	logic                       in_acc;
	logic                       cfg_acc;
	logic                       start_stream;
	logic signed [SUMW-1:0]     start_sum;
	logic                       ram_we;
	logic [AW-1:0]              ram_raddr;
	logic [SAMPLE_W-1:0]        ram_rdata;
	logic signed [SAMPLE_W-1:0] old_val;
	logic signed [SUMW-1:0]     sum_upd;
	logic                       emit;
	logic [RW-1:0]              pend_nxt;
	logic [SUMW-1:0]            mag;
	logic [SUMW-1:0]            dividend;
	logic                       div_start;
	logic                       div_done;
	logic [SUMW-1:0]            quotient;
	logic signed [SAMPLE_W-1:0] avg_w;
	logic                       out_free;
	logic                       do_adv;
	logic                       adv_flush;
	logic                       adv_more;
	logic                       stream_end;

	assign r_eff = (int'(radius_q) > MAX_RADIUS) ? RW'(MAX_RADIUS) : RW'(radius_q);
	assign len_w = {r_eff, 1'b1};

	assign cfg_ready = (state_q == ST_IDLE);
	assign in_stall  = (state_q != ST_IDLE);
	assign cfg_acc   = cfg_valid && cfg_ready;
	assign in_acc    = in_valid && !in_stall;

	// A new stream starts when nothing is owed from the previous one.
	assign start_stream = (seen_q == '0) && (pend_q == '0);
	assign start_sum    = $signed({{AW{sample[SAMPLE_W-1]}}, sample})
	                    * $signed({{SAMPLE_W{1'b0}}, len_w});

	assign ram_we    = (state_q == ST_PUSH);
	assign ram_raddr = head_q - len_w;

	ecma_ram #(
		.WIDTH (SAMPLE_W),
		.DEPTH (DEPTH)
	) u_ring (
		.clk   (clk),
		.we    (ram_we),
		.waddr (head_q),
		.wdata (s_q),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	// Until len pushes of this stream have landed, the leaving sample is
	// a replica of the first sample.
	assign old_val = (cnt_q < len_w) ? first_q : $signed(ram_rdata);
	assign sum_upd = sum_q - $signed({{AW{old_val[SAMPLE_W-1]}}, old_val})
	               + $signed({{AW{s_q[SAMPLE_W-1]}}, s_q});

	assign emit     = (seen_q >= r_eff);
	assign pend_nxt = (pend_q != '0) ? pend_q - 1'b1 : '0;

	// Round half away from zero on the magnitude; len is odd.
	assign mag       = sum_q[SUMW-1] ? SUMW'(-sum_q) : SUMW'(sum_q);
	assign dividend  = mag + SUMW'(r_eff);
	assign div_start = (state_q == ST_DIVGO);

	ecma_div #(
		.DW (SUMW),
		.VW (AW)
	) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (dividend),
		.divisor  (len_w),
		.done     (div_done),
		.quotient (quotient)
	);

	always_comb begin
		if (sum_q[SUMW-1]) begin
			if (quotient >= SUMW'(32768)) begin
				avg_w = AVG_NEG_LIMIT;
			end else begin
				avg_w = -$signed(quotient[SAMPLE_W-1:0]);
			end
		end else begin
			if (quotient > SUMW'(32767)) begin
				avg_w = AVG_POS_LIMIT;
			end else begin
				avg_w = $signed(quotient[SAMPLE_W-1:0]);
			end
		end
	end

	assign out_free   = !out_valid_q || !out_stall;
	assign do_adv     = ((state_q == ST_UPD) && !emit) || ((state_q == ST_OUT) && out_free);
	assign adv_flush  = !flush_q && last_q && (r_eff != '0);
	assign adv_more   = flush_q && (k_q != RW'(r_eff - 1'b1));
	assign stream_end = do_adv && !adv_flush && !adv_more && last_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			radius_q    <= '0;
			seen_q      <= '0;
			pend_q      <= '0;
			k_q         <= '0;
			head_q      <= '0;
			cnt_q       <= '0;
			sum_q       <= '0;
			s_q         <= '0;
			first_q     <= '0;
			last_q      <= 1'b0;
			flush_q     <= 1'b0;
			fin_q       <= 1'b0;
			out_valid_q <= 1'b0;
			average_q   <= '0;
			final_q     <= 1'b0;
		end else begin
			if ((state_q != ST_OUT) && out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
			if (cfg_acc) begin
				radius_q <= cfg_data;
				seen_q   <= '0;
				pend_q   <= '0;
			end
			case (state_q)
				ST_IDLE: begin
					if (in_acc) begin
						s_q     <= sample;
						last_q  <= last;
						flush_q <= 1'b0;
						if (start_stream) begin
							sum_q   <= start_sum;
							cnt_q   <= '0;
							first_q <= sample;
						end
						state_q <= ST_PUSH;
					end
				end
				ST_PUSH: begin
					head_q  <= head_q + 1'b1;
					state_q <= ST_UPD;
				end
				ST_UPD: begin
					sum_q <= sum_upd;
					if (cnt_q < len_w) begin
						cnt_q <= cnt_q + 1'b1;
					end
					if (emit) begin
						if (flush_q) begin
							pend_q <= pend_nxt;
							fin_q  <= (pend_nxt == '0);
						end else begin
							fin_q <= last_q && (r_eff == '0);
						end
						state_q <= ST_DIVGO;
					end else if (!stream_end) begin
						seen_q <= seen_q + 1'b1;
						if (!flush_q) begin
							pend_q <= pend_q + 1'b1;
						end
					end
				end
				ST_DIVGO: begin
					state_q <= ST_DIV;
				end
				ST_DIV: begin
					if (div_done) begin
						state_q <= ST_OUT;
					end
				end
				ST_OUT: begin
					if (out_free) begin
						out_valid_q <= 1'b1;
						average_q   <= avg_w;
						final_q     <= fin_q;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
			// Move on to the next padded push, or finish the request.
			if (do_adv) begin
				if (adv_flush) begin
					flush_q <= 1'b1;
					k_q     <= '0;
					state_q <= ST_PUSH;
				end else if (adv_more) begin
					k_q     <= k_q + 1'b1;
					state_q <= ST_PUSH;
				end else begin
					state_q <= ST_IDLE;
					if (last_q) begin
						seen_q <= '0;
						pend_q <= '0;
					end
				end
			end
		end
	end

	assign out_valid = out_valid_q;
	assign average   = average_q;
	assign final_res = final_q;

	`ECMA_ASSERT_ALWAYS(a_seen_bounded, seen_q <= r_eff)
	`ECMA_ASSERT_ALWAYS(a_pend_le_seen, pend_q <= seen_q)
	`ECMA_ASSERT_IMPLIES(a_div_done_in_wait, div_done, state_q == ST_DIV)
	`ECMA_ASSERT_NEXT(a_out_loaded, (state_q == ST_OUT) && out_free, out_valid_q)

endmodule
